@@ rtl/tti_pkg.sv @@
// Package of the trajectory time interpolator: item codes, table entry
// type, control states and fixed-point constants. No dependencies.
package tti_pkg;

  localparam int MAX_POINTS_DEF = 256;

  // Heading constants in Q3.12 radians.
  localparam logic signed [16:0] YAW_PI     = 17'sd12868;
  localparam logic signed [16:0] YAW_TWO_PI = 17'sd25736;

  // Number of quotient bits of the Q1.16 fraction (it reaches 65536).
  localparam int FRAC_W = 17;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic signed [31:0] time_q;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [14:0] yaw;
    logic signed [15:0] speed;
    logic               pushing;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_RD_LAST,
    ST_CHK_LAST,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_I1,
    ST_LD_I1,
    ST_RD_I0,
    ST_LD_I0,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

@@ rtl/tti_if.sv @@
// Item channel interfaces of the trajectory time interpolator.
// Depends on nothing but the widths of the item fields.
interface tti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] point_time;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [14:0] point_yaw;
  logic signed [15:0] point_speed;
  logic               point_pushing;
  logic signed [31:0] query_time;

  modport source (output valid, func, point_time, point_x, point_y, point_yaw,
                  point_speed, point_pushing, query_time, input ready);
  modport sink (input valid, func, point_time, point_x, point_y, point_yaw,
                point_speed, point_pushing, query_time, output ready);
endinterface

interface tti_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [15:0] ref_yaw;
  logic signed [15:0] ref_speed;
  logic               ref_pushing;

  modport source (output valid, ok, ref_x, ref_y, ref_yaw, ref_speed, ref_pushing,
                  input ready);
  modport sink (input valid, ok, ref_x, ref_y, ref_yaw, ref_speed, ref_pushing,
                output ready);
endinterface

@@ rtl/trajectory_time_interpolator_unit.sv @@
// Top level of the trajectory time interpolator: point table memory,
// lookup sequencer, serial divider and blend unit. Uses tti_pkg and tti_if.
//
// Usage: items arrive on in_if (func selects clear, append or query) and
// every item gives exactly one result item on out_if. A clear or an append
// answers in the cycle after it is taken. A query walks the point table in a
// memory with one registered read port: two reads test the ends of the
// table, a binary search reads and compares at each probe (at most
// log2(points) + 1 probes), two reads fetch the enclosing pair, a restoring
// divider forms the 17-bit fraction and one shared multiplier blends x, y,
// yaw and speed in turn, a multiply and then an add for each. A query that
// falls outside the table returns the stored end point and skips the rest.
// The block works on one item at a time; in_if.ready is high when the
// sequencer is idle and the output register is empty or being emptied. A
// finished query waits in its own result registers while the receiver
// stalls. Synchronous reset empties the table (the count returns to zero;
// the memory itself is not cleared) and sets trajectory_start to zero.
// cfg_wr_en writes trajectory_start; do so only while no item is in flight.
module trajectory_time_interpolator_unit
  import tti_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  tti_in_if.sink            in_if,
  tti_out_if.source         out_if
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_POINTS);

  // Point table memory.
  entry_t           mem [MAX_POINTS];
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data_r;
  logic             wr_en;
  entry_t           wr_data;

  // Control and bookkeeping.
  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r;
  logic signed [31:0]    last_time_r;
  logic signed [31:0]    start_r;
  logic signed [32:0]    rel_r;
  logic [CW-1:0]         lo_r, hi_r;
  logic [CW-1:0]         mid, lo_upd, hi_upd, lo_m1, n_m1;
  logic                  probe_lt, srch_done;

  // Enclosing pair, divider and blend unit.
  entry_t                e0_r, e1_r;
  logic [33:0]           rem_r;
  logic [FRAC_W-1:0]     qd_r;
  logic [33:0]           den_r;
  logic [4:0]            div_cnt_r;
  logic [1:0]            ch_r;
  logic signed [51:0]    prod_r;

  // Query result, held until the output register is free.
  logic signed [31:0]    res_x_r, res_y_r;
  logic signed [15:0]    res_yaw_r, res_speed_r;
  logic                  res_push_r, res_ok_r;

  // Output register.
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic signed [31:0]    out_x_r, out_y_r;
  logic signed [15:0]    out_yaw_r, out_speed_r;
  logic                  out_push_r;

  logic                  in_fire, out_free;
  logic                  append_ok;
  logic signed [32:0]    rd_time_ext;

  assign out_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire    = in_if.valid && in_if.ready;

  assign append_ok  = (count_r != FULL_COUNT) &&
                      ((count_r == '0) || (in_if.point_time >= last_time_r));
  assign wr_en      = in_fire && (in_if.func == FUNC_APPEND) && append_ok;
  assign wr_data    = '{time_q: in_if.point_time, x: in_if.point_x, y: in_if.point_y,
                        yaw: in_if.point_yaw, speed: in_if.point_speed,
                        pushing: in_if.point_pushing};

  assign rd_time_ext = 33'(rd_data_r.time_q);

  // Binary search step: the lower bound moves past a probe below rel.
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign probe_lt  = rd_time_ext < rel_r;
  assign lo_upd    = probe_lt ? (mid + 1'b1) : lo_r;
  assign hi_upd    = probe_lt ? hi_r : mid;
  assign srch_done = lo_upd >= hi_upd;
  assign lo_m1     = lo_r - 1'b1;
  assign n_m1      = count_r - 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_if.func == FUNC_QUERY) && (count_r != '0)) begin
          state_nxt = ST_RD_FIRST;
        end
      end
      ST_RD_FIRST: begin
        state_nxt = ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        state_nxt = (rel_r <= rd_time_ext) ? ST_DONE : ST_RD_LAST;
      end
      ST_RD_LAST: begin
        rd_addr   = n_m1[AW-1:0];
        state_nxt = ST_CHK_LAST;
      end
      ST_CHK_LAST: begin
        state_nxt = (rel_r >= rd_time_ext) ? ST_DONE : ST_SRCH_RD;
      end
      ST_SRCH_RD: begin
        rd_addr   = mid[AW-1:0];
        state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        state_nxt = srch_done ? ST_RD_I1 : ST_SRCH_RD;
      end
      ST_RD_I1: begin
        rd_addr   = lo_r[AW-1:0];
        state_nxt = ST_LD_I1;
      end
      ST_LD_I1: begin
        state_nxt = ST_RD_I0;
      end
      ST_RD_I0: begin
        rd_addr   = lo_m1[AW-1:0];
        state_nxt = ST_LD_I0;
      end
      ST_LD_I0: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == 5'(FRAC_W - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = (ch_r == 2'd3) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Table count, start time and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (in_fire && (in_if.func == FUNC_CLEAR)) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (in_fire && (in_if.func != FUNC_QUERY || count_r == '0)) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath combinational terms.
  logic [32:0]        num;
  logic [33:0]        den;
  logic [49:0]        dividend;
  logic [34:0]        trial;
  logic signed [16:0] dyaw;
  logic signed [33:0] blend_d, blend_a;
  logic signed [51:0] rounded;
  logic signed [35:0] blend_sum;

  // While loading the earlier point, rd_data_r holds it and e1_r the later one.
  assign num      = 33'(rel_r - 33'(rd_data_r.time_q));
  assign den      = 34'(34'(e1_r.time_q) - 34'(rd_data_r.time_q));
  assign dividend = {num[32:0], 16'b0} + 50'(den >> 1);
  assign trial    = {rem_r, qd_r[FRAC_W-1]};

  always_comb begin
    dyaw = 17'(e1_r.yaw) - 17'(e0_r.yaw);
    if (dyaw >= YAW_PI) begin
      dyaw = dyaw - YAW_TWO_PI;
    end else if (dyaw < -YAW_PI) begin
      dyaw = dyaw + YAW_TWO_PI;
    end
    case (ch_r)
      2'd0: begin
        blend_d = 34'(e1_r.x) - 34'(e0_r.x);
        blend_a = 34'(e0_r.x);
      end
      2'd1: begin
        blend_d = 34'(e1_r.y) - 34'(e0_r.y);
        blend_a = 34'(e0_r.y);
      end
      2'd2: begin
        blend_d = 34'(dyaw);
        blend_a = 34'(e0_r.yaw);
      end
      default: begin
        blend_d = 34'(e1_r.speed) - 34'(e0_r.speed);
        blend_a = 34'(e0_r.speed);
      end
    endcase
    rounded   = prod_r + 52'sd32768;
    blend_sum = 36'(blend_a) + 36'(rounded >>> 16);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rel_r    <= 33'(in_if.query_time) - 33'(start_r);
        lo_r     <= '0;
        hi_r     <= count_r;
        res_ok_r <= 1'b1;
        if (wr_en) begin
          last_time_r <= in_if.point_time;
        end
      end
      ST_CHK_FIRST, ST_CHK_LAST: begin
        res_x_r     <= rd_data_r.x;
        res_y_r     <= rd_data_r.y;
        res_yaw_r   <= 16'(rd_data_r.yaw);
        res_speed_r <= rd_data_r.speed;
        res_push_r  <= rd_data_r.pushing;
      end
      ST_SRCH_CMP: begin
        lo_r <= lo_upd;
        hi_r <= hi_upd;
      end
      ST_LD_I1: begin
        e1_r <= rd_data_r;
      end
      ST_LD_I0: begin
        // rd_data_r holds the earlier point; the pair spans den > 0.
        e0_r      <= rd_data_r;
        den_r     <= den;
        rem_r     <= 34'(dividend[49:FRAC_W]);
        qd_r      <= dividend[FRAC_W-1:0];
        div_cnt_r <= '0;
        ch_r      <= '0;
      end
      ST_DIV: begin
        if (trial >= 35'(den_r)) begin
          rem_r <= 34'(trial - 35'(den_r));
          qd_r  <= {qd_r[FRAC_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[33:0];
          qd_r  <= {qd_r[FRAC_W-2:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_MUL: begin
        prod_r <= 52'(blend_d * $signed({1'b0, qd_r}));
      end
      ST_ADD: begin
        case (ch_r)
          2'd0:    res_x_r     <= blend_sum[31:0];
          2'd1:    res_y_r     <= blend_sum[31:0];
          2'd2:    res_yaw_r   <= blend_sum[15:0];
          default: begin
            res_speed_r <= blend_sum[15:0];
            res_push_r  <= e1_r.pushing;
          end
        endcase
        ch_r <= ch_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output payload: immediate answers for clear, append and failed items,
  // otherwise the held query result.
  always_ff @(posedge clk) begin
    if (in_fire && (in_if.func != FUNC_QUERY || count_r == '0)) begin
      out_ok_r    <= (in_if.func == FUNC_CLEAR) ||
                     ((in_if.func == FUNC_APPEND) && append_ok);
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_yaw_r   <= '0;
      out_speed_r <= '0;
      out_push_r  <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_ok_r    <= res_ok_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_yaw_r   <= res_yaw_r;
      out_speed_r <= res_speed_r;
      out_push_r  <= res_push_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.ok          = out_ok_r;
  assign out_if.ref_x       = out_x_r;
  assign out_if.ref_y       = out_y_r;
  assign out_if.ref_yaw     = out_yaw_r;
  assign out_if.ref_speed   = out_speed_r;
  assign out_if.ref_pushing = out_push_r;

endmodule

@@ rtl/tti_checker.sv @@
// Port-level checks of the trajectory time interpolator and their binding.
// Depends on trajectory_time_interpolator_unit and the tti_if interfaces.
module tti_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               ok,
  input logic signed [31:0] ref_x,
  input logic signed [31:0] ref_y,
  input logic signed [15:0] ref_yaw,
  input logic signed [15:0] ref_speed,
  input logic               ref_pushing
);

  // A waiting result is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

  // No new item is taken while a stalled result occupies the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid && !out_ready))
    else $error("input taken while result stalled");

  // A failed item carries an all-zero result.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ok |-> ref_x == 0 && ref_y == 0 && ref_yaw == 0 &&
                         ref_speed == 0 && !ref_pushing)
    else $error("failed result carries nonzero fields");

endmodule

bind trajectory_time_interpolator_unit tti_checker u_tti_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .ok          (out_if.ok),
  .ref_x       (out_if.ref_x),
  .ref_y       (out_if.ref_y),
  .ref_yaw     (out_if.ref_yaw),
  .ref_speed   (out_if.ref_speed),
  .ref_pushing (out_if.ref_pushing)
);

@@ dv/trajectory_time_interpolator_unit_tb.sv @@
// Self-checking testbench of trajectory_time_interpolator_unit: directed items,
// then random trajectory build-ups and lookups, compared against its own predictor.
// Depends on tti_pkg, tti_if and the top level in rtl.
module trajectory_time_interpolator_unit_tb;
  import tti_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_AFTER = 1100;
  localparam int YAW_MAX = 12868;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [14:0] point_yaw;
    logic signed [15:0] point_speed;
    logic               point_pushing;
    logic signed [31:0] query_time;
  } item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [15:0] ref_yaw;
    logic signed [15:0] ref_speed;
    logic               ref_pushing;
  } answer_t;

  // A directed row either carries a typed-in answer or relies on the predictor.
  typedef struct packed {
    item_t   it;
    logic    typed;
    answer_t ans;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  tti_in_if  in_bus ();
  tti_out_if out_bus ();

  trajectory_time_interpolator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // Predictor copy of the point table, its fill level and the start time.
  longint tbl_time [TABLE_DEPTH];
  longint tbl_x [TABLE_DEPTH];
  longint tbl_y [TABLE_DEPTH];
  longint tbl_yaw [TABLE_DEPTH];
  longint tbl_speed [TABLE_DEPTH];
  bit     tbl_push [TABLE_DEPTH];
  int     tbl_count;
  longint start_time;

  answer_t pending_answers[$];
  int  mismatches;
  int  items_sent;
  int  answers_seen;
  int  lookups_ok;
  int  appends_refused;
  bit  quiet;
  row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run; far beyond the slowest correct run.
  initial begin
    #30000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Linear blend with rounding: a + floor((f * d + 32768) / 65536).
  function automatic longint blend_q16(longint a, longint d, longint f);
    return a + ((d * f + 64'sd32768) >>> 16);
  endfunction

  function automatic answer_t stored_point(int i);
    answer_t r;
    r.ok = 1'b1;
    r.ref_x = tbl_x[i][31:0];
    r.ref_y = tbl_y[i][31:0];
    r.ref_yaw = tbl_yaw[i][15:0];
    r.ref_speed = tbl_speed[i][15:0];
    r.ref_pushing = tbl_push[i];
    return r;
  endfunction

  // Interpolated lookup of a relative time (33 bits wide, never wraps).
  function automatic answer_t trajectory_lookup(longint rel);
    answer_t r;
    int lo, hi, mid;
    longint num, den, frac, dyaw;
    r = '0;
    if (tbl_count == 0) return r;
    if (rel <= tbl_time[0]) return stored_point(0);
    if (rel >= tbl_time[tbl_count-1]) return stored_point(tbl_count - 1);
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_time[mid] < rel) lo = mid + 1;
      else hi = mid;
    end
    num = rel - tbl_time[lo-1];
    den = tbl_time[lo] - tbl_time[lo-1];
    frac = ((num <<< 16) + den / 2) / den;
    // Heading difference is taken the short way round, into [-pi, pi).
    dyaw = tbl_yaw[lo] - tbl_yaw[lo-1];
    while (dyaw >= YAW_MAX) dyaw -= 2 * YAW_MAX;
    while (dyaw < -YAW_MAX) dyaw += 2 * YAW_MAX;
    r.ok = 1'b1;
    r.ref_x = 32'(blend_q16(tbl_x[lo-1], tbl_x[lo] - tbl_x[lo-1], frac));
    r.ref_y = 32'(blend_q16(tbl_y[lo-1], tbl_y[lo] - tbl_y[lo-1], frac));
    r.ref_yaw = 16'(blend_q16(tbl_yaw[lo-1], dyaw, frac));
    r.ref_speed = 16'(blend_q16(tbl_speed[lo-1], tbl_speed[lo] - tbl_speed[lo-1], frac));
    r.ref_pushing = tbl_push[lo];
    return r;
  endfunction

  // Applies one item to the predictor table and returns its answer.
  function automatic answer_t trajectory_step(item_t it);
    answer_t r;
    longint t;
    r = '0;
    case (it.func)
      FUNC_CLEAR: begin
        tbl_count = 0;
        r.ok = 1'b1;
      end
      FUNC_APPEND: begin
        t = it.point_time;
        if (tbl_count < TABLE_DEPTH &&
            (tbl_count == 0 || t >= tbl_time[tbl_count-1])) begin
          tbl_time[tbl_count] = t;
          tbl_x[tbl_count] = it.point_x;
          tbl_y[tbl_count] = it.point_y;
          tbl_yaw[tbl_count] = it.point_yaw;
          tbl_speed[tbl_count] = it.point_speed;
          tbl_push[tbl_count] = it.point_pushing;
          tbl_count++;
          r.ok = 1'b1;
        end else begin
          appends_refused++;
        end
      end
      FUNC_QUERY: begin
        r = trajectory_lookup(longint'(it.query_time) - start_time);
        if (r.ok) lookups_ok++;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic item_t make_item(func_t fn, longint pt, longint px, longint py,
                                      int pyaw, int pspd, bit ppush, longint qt);
    item_t it;
    it.func = fn;
    it.point_time = pt[31:0];
    it.point_x = px[31:0];
    it.point_y = py[31:0];
    it.point_yaw = pyaw[14:0];
    it.point_speed = pspd[15:0];
    it.point_pushing = ppush;
    it.query_time = qt[31:0];
    return it;
  endfunction

  // Fully random item; every field bit is exercised through these.
  function automatic item_t noise_item();
    item_t it;
    it.func = func_t'($urandom_range(0, 3));
    it.point_time = $urandom;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_yaw = 15'($urandom_range(0, 2 * YAW_MAX) - YAW_MAX);
    it.point_speed = 16'($urandom);
    it.point_pushing = 1'($urandom_range(0, 1));
    it.query_time = $urandom;
    return it;
  endfunction

  // Presents one item, holds it until accepted, then records what it should give.
  // Returns at a rising edge; a random gap may follow.
  task automatic send_item(item_t it, bit typed, answer_t typed_ans);
    answer_t predicted;
    in_bus.valid <= 1'b1;
    in_bus.func <= it.func;
    in_bus.point_time <= it.point_time;
    in_bus.point_x <= it.point_x;
    in_bus.point_y <= it.point_y;
    in_bus.point_yaw <= it.point_yaw;
    in_bus.point_speed <= it.point_speed;
    in_bus.point_pushing <= it.point_pushing;
    in_bus.query_time <= it.query_time;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // The predictor always runs so that its table follows the block's.
    predicted = trajectory_step(it);
    pending_answers.push_back(typed ? typed_ans : predicted);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_checked(item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Writes trajectory_start once the block has drained; a clear or an append
  // always answers, so an empty queue means nothing is in flight.
  task automatic write_start(longint value);
    int guard;
    in_bus.valid <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[31:0];
    @(posedge clk);
    start_time = longint'($signed(value[31:0]));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic answer_t fixed_answer(bit ok, longint x, longint y, int yaw,
                                           int spd, bit push);
    answer_t r;
    r.ok = ok;
    r.ref_x = x[31:0];
    r.ref_y = y[31:0];
    r.ref_yaw = yaw[15:0];
    r.ref_speed = spd[15:0];
    r.ref_pushing = push;
    return r;
  endfunction

  task automatic add_row(item_t it, bit typed, answer_t ans);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.ans = ans;
    dir_rows.push_back(r);
  endtask

  // Random trajectory: clear, npts appends with mostly rising times, then
  // mostly lookups, spread from before the first point to past the last one.
  task automatic random_trajectory(int npts, int nq);
    longint t, span, qrel;
    item_t it;
    send_checked(make_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    t = longint'($signed($urandom)) >>> $urandom_range(4, 20);
    for (int i = 0; i < npts; i++) begin
      it = noise_item();
      it.func = FUNC_APPEND;
      if ($urandom_range(0, 15) == 0) begin
        it.point_time = 32'(t - $urandom_range(1, 5000));
      end else begin
        if ($urandom_range(0, 7) != 0) t = t + $urandom_range(0, 1 << $urandom_range(0, 16));
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        it.point_time = t[31:0];
      end
      send_checked(it);
    end
    span = t - tbl_time[0] + 4096;
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 9) == 0) begin
        it = noise_item();
      end else begin
        it = noise_item();
        it.func = FUNC_QUERY;
        qrel = (tbl_count > 0 ? tbl_time[0] : 0) - span / 8 +
               longint'($urandom_range(0, 1000000)) * (span + span / 4) / 1000000;
        if ($urandom_range(0, 5) == 0 && tbl_count > 0)
          qrel = tbl_time[$urandom_range(0, tbl_count - 1)];
        qrel = qrel + start_time;
        it.query_time = qrel[31:0];
      end
      send_checked(it);
    end
  endtask

  // Result side: random stall bursts until the quiet tail of the run.
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing expected, ok=%0b x=%0d", $time,
                 out_bus.ok, out_bus.ref_x);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (out_bus.ok !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_bus.ok);
          mismatches++;
        end
        if (out_bus.ref_x !== want.ref_x) begin
          $display("%0t: ref_x expected %0d actual %0d", $time, want.ref_x, out_bus.ref_x);
          mismatches++;
        end
        if (out_bus.ref_y !== want.ref_y) begin
          $display("%0t: ref_y expected %0d actual %0d", $time, want.ref_y, out_bus.ref_y);
          mismatches++;
        end
        if (out_bus.ref_yaw !== want.ref_yaw) begin
          $display("%0t: ref_yaw expected %0d actual %0d", $time, want.ref_yaw,
                   out_bus.ref_yaw);
          mismatches++;
        end
        if (out_bus.ref_speed !== want.ref_speed) begin
          $display("%0t: ref_speed expected %0d actual %0d", $time, want.ref_speed,
                   out_bus.ref_speed);
          mismatches++;
        end
        if (out_bus.ref_pushing !== want.ref_pushing) begin
          $display("%0t: ref_pushing expected %0b actual %0b", $time, want.ref_pushing,
                   out_bus.ref_pushing);
          mismatches++;
        end
      end
    end
  end

  initial begin
    longint starts [4];
    int guard;
    int ph;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_NOP;
    in_bus.point_time = '0;
    in_bus.point_x = '0;
    in_bus.point_y = '0;
    in_bus.point_yaw = '0;
    in_bus.point_speed = '0;
    in_bus.point_pushing = 1'b0;
    in_bus.query_time = '0;
    out_bus.ready = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    mismatches = 0;
    tbl_count = 0;
    start_time = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Typed answers are the ones that follow from the item alone.
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, '0);          // empty table
    add_row(make_item(FUNC_NOP, -1, -1, -1, -1, -1, 1, -1), 1, '0);      // no operation
    add_row(make_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, fixed_answer(1, 0, 0, 0, 0, 0));
    add_row(make_item(FUNC_APPEND, 0, 64'sh7fffffff, -64'sh80000000, YAW_MAX, 32767, 1, 0),
            1, fixed_answer(1, 0, 0, 0, 0, 0));
    add_row(make_item(FUNC_APPEND, 4096, -64'sh80000000, 64'sh7fffffff, -YAW_MAX, -32768,
                      0, 0), 1, fixed_answer(1, 0, 0, 0, 0, 0));
    // A time below the last stored one is refused and the table stays sorted.
    add_row(make_item(FUNC_APPEND, 100, 5, 5, 5, 5, 1, 0), 1, '0);
    // Equal times are allowed.
    add_row(make_item(FUNC_APPEND, 4096, 65536, 65536, 0, 256, 1, 0),
            1, fixed_answer(1, 0, 0, 0, 0, 0));
    // Before the first point: that point comes back as stored.
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, -64'sh80000000), 1,
            fixed_answer(1, 64'sh7fffffff, -64'sh80000000, YAW_MAX, 32767, 1));
    // Past the last point.
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 64'sh7fffffff), 1,
            fixed_answer(1, 65536, 65536, 0, 256, 1));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 2048), 0, '0);  // heading wraps by 2 pi
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 1), 0, '0);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 4095), 0, '0);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 4096), 0, '0);
    add_row(make_item(FUNC_APPEND, 64'sh7fffffff, 3, -3, 100, 7, 0, 0),
            1, fixed_answer(1, 0, 0, 0, 0, 0));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 64'sh40000000), 0, '0);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 64'sh7ffffffe), 0, '0);
    add_row(make_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, fixed_answer(1, 0, 0, 0, 0, 0));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 5), 1, '0);

    write_start(0);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].ans);

    // Random part: each phase runs under its own start time, extremes included.
    starts[0] = -64'sh80000000;
    starts[1] = 64'sh7fffffff;
    starts[2] = 0;
    starts[3] = 0;
    ph = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (ph < 3) write_start(starts[ph]);
      else if (ph % 2 == 0) write_start(longint'($signed($urandom)));
      else write_start(longint'($signed($urandom)) >>> 12);
      // One pass fills the table past its depth so that appends get refused.
      if (ph == 3) random_trajectory(TABLE_DEPTH + 3, 40);
      else repeat (3) random_trajectory($urandom_range(1, 24), $urandom_range(10, 40));
      ph++;
      if (items_sent > QUIET_AFTER) quiet = 1'b1;
    end

    in_bus.valid <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);

    $display("Ran %0d items in %0d start-time phases; %0d results checked.",
             items_sent, ph, answers_seen);
    $display("Lookups answered: %0d, appends refused: %0d.", lookups_ok, appends_refused);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (pending_answers.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tti_pkg.sv
rtl/tti_if.sv
rtl/trajectory_time_interpolator_unit.sv
rtl/tti_checker.sv
dv/trajectory_time_interpolator_unit_tb.sv
